// File: hdl/aswdm_pkg.sv
// Shared types and codes for the alive-supervision watchdog manager.
// Used by aswdm_cell and alive_supervision_watchdog_manager_unit.
// No dependencies.
package aswdm_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int ENT_W    = 3;
   localparam int ALIVE_W  = 16;
   localparam int TOL_W    = 8;
   localparam int CNT_W    = 4;
   localparam int ERR_W    = 2;
   localparam int STAT_W   = 2;
   localparam int EXP_W    = 4;

   // how many cells an index / count field can ever reach
   localparam int ENT_LIMIT = 2 ** ENT_W;
   localparam int CNT_LIMIT = 2 ** CNT_W;

   localparam int DEF_MAX_ENTITIES = 8;
   localparam logic [CNT_W-1:0] DEF_ENTITY_COUNT = 4'd1;

   // operation codes
   localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_CHKPT = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NOT_INIT = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

   // entity status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FAILED  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EXPIRED = 2'd2;

   localparam logic [TOL_W-1:0] FC_MAX = 8'hFF;

   // command broadcast to every cell; strobes are already qualified
   typedef struct packed {
      logic                 init;
      logic                 load;
      logic                 chkpt;
      logic [ALIVE_W-1:0]   alive_min;
      logic [ALIVE_W-1:0]   alive_max;
      logic [TOL_W-1:0]     tol;
   } cmd_type;

   // walk token handed from cell to cell during a main tick
   typedef struct packed {
      logic                 valid;
      logic                 all_ok;
      logic [EXP_W-1:0]     expired;
   } token_type;

endpackage

// File: hdl/alive_supervision_watchdog_manager_unit.sv
// Alive-supervision watchdog manager: top level, control and result register.
// Depends on aswdm_pkg and aswdm_cell.
//
// Each request carries one operation (init, load limits, checkpoint, main
// tick, query) and yields exactly one response. Init, load, checkpoint,
// query and every rejected request have their response registered at the
// accepting edge. A main tick sends a token down the row of MAX_ENTITIES
// cells, one cell per cycle, and its response is registered when the token
// leaves the last cell; the request side stalls during the walk. The
// response register holds one result, and a new request is taken while that
// result is transferred. csr_wr_data sets the active entity count; the user
// must write it only while the block is idle, as the block does not enforce it.
module alive_supervision_watchdog_manager_unit #(
   parameter int MAX_ENTITIES = aswdm_pkg::DEF_MAX_ENTITIES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [aswdm_pkg::OP_W-1:0]        req_op,
   input  logic [aswdm_pkg::ENT_W-1:0]       req_entity,
   input  logic [aswdm_pkg::ALIVE_W-1:0]     req_alive_min,
   input  logic [aswdm_pkg::ALIVE_W-1:0]     req_alive_max,
   input  logic [aswdm_pkg::TOL_W-1:0]       req_fail_tolerance,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic [aswdm_pkg::ERR_W-1:0]       rsp_error_code,
   output logic [aswdm_pkg::STAT_W-1:0]      rsp_local_status,
   output logic                              rsp_global_status,
   output logic                              rsp_feed_toggle,
   output logic [aswdm_pkg::EXP_W-1:0]       rsp_newly_expired,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [aswdm_pkg::CNT_W-1:0]       csr_wr_data
);

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_WALK = 1'b1;

   logic                             state_ff, state_in;
   logic                             init_ff, init_in;
   logic                             ovf_ff, ovf_in;
   logic [aswdm_pkg::CNT_W-1:0]      count_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             acc_ff, acc_in;
   logic [aswdm_pkg::ERR_W-1:0]      err_ff, err_in;
   logic [aswdm_pkg::STAT_W-1:0]     lstat_ff, lstat_in;
   logic                             gstat_ff, gstat_in;
   logic                             feed_ff, feed_in;
   logic [aswdm_pkg::EXP_W-1:0]      exp_ff, exp_in;
   logic                             rsp_load;

   logic                             req_xfer;
   logic                             in_range;
   logic                             walk_start;
   logic                             walk_done;
   aswdm_pkg::cmd_type               cmd;
   aswdm_pkg::token_type             tok [MAX_ENTITIES+1];
   logic [MAX_ENTITIES-1:0]          sel;
   logic [MAX_ENTITIES-1:0]          active;
   logic [aswdm_pkg::STAT_W-1:0]     rd_status [MAX_ENTITIES];
   logic [aswdm_pkg::STAT_W-1:0]     query_status;

   assign req_stall = (state_ff == FSM_WALK) || (rsp_valid_ff && rsp_stall);
   assign req_xfer  = req_valid && !req_stall;

   assign in_range = ({1'b0, req_entity} < count_ff) &&
                     (int'(req_entity) < MAX_ENTITIES);

   assign walk_start = req_xfer && (req_op == aswdm_pkg::OP_TICK) && init_ff;
   assign walk_done  = tok[MAX_ENTITIES].valid;

   // qualified command strobes for the cell row
   always_comb begin
      cmd.init      = req_xfer && (req_op == aswdm_pkg::OP_INIT);
      cmd.load      = req_xfer && (req_op == aswdm_pkg::OP_LOAD) && in_range;
      cmd.chkpt     = req_xfer && (req_op == aswdm_pkg::OP_CHKPT) && init_ff && in_range;
      cmd.alive_min = req_alive_min;
      cmd.alive_max = req_alive_max;
      cmd.tol       = req_fail_tolerance;
   end

   // walk token entering the first cell
   assign tok[0] = '{valid: walk_start, all_ok: 1'b1, expired: '0};

   // row of supervision cells
   for (genvar i = 0; i < MAX_ENTITIES; i++) begin : g_cell
      if (i < aswdm_pkg::ENT_LIMIT) begin : g_sel
         assign sel[i] = (req_entity == aswdm_pkg::ENT_W'(i));
      end else begin : g_nosel
         assign sel[i] = 1'b0;
      end
      if (i < aswdm_pkg::CNT_LIMIT) begin : g_act
         assign active[i] = (aswdm_pkg::CNT_W'(i) < count_ff);
      end else begin : g_noact
         assign active[i] = 1'b0;
      end

      aswdm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel[i]),
         .active    (active[i]),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .rd_status (rd_status[i])
      );
   end

   // query readback: unselected cells read as zero
   always_comb begin
      query_status = '0;
      for (int i = 0; i < MAX_ENTITIES; i++) begin
         query_status = query_status | rd_status[i];
      end
   end

   // result and control next state
   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      ovf_in   = ovf_ff;
      rsp_load = 1'b0;
      acc_in   = 1'b0;
      err_in   = aswdm_pkg::ERR_NONE;
      lstat_in = aswdm_pkg::STAT_OK;
      gstat_in = ovf_ff;
      feed_in  = 1'b0;
      exp_in   = '0;
      if (state_ff == FSM_WALK) begin
         if (walk_done) begin
            state_in = FSM_IDLE;
            rsp_load = 1'b1;
            acc_in   = 1'b1;
            ovf_in   = !tok[MAX_ENTITIES].all_ok;
            gstat_in = !tok[MAX_ENTITIES].all_ok;
            feed_in  = tok[MAX_ENTITIES].all_ok;
            exp_in   = tok[MAX_ENTITIES].expired;
         end
      end else if (req_xfer) begin
         rsp_load = 1'b1;
         unique case (req_op)
            aswdm_pkg::OP_INIT: begin
               init_in  = 1'b1;
               ovf_in   = 1'b0;
               gstat_in = 1'b0;
               acc_in   = 1'b1;
            end
            aswdm_pkg::OP_LOAD: begin
               if (in_range) acc_in = 1'b1;
               else          err_in = aswdm_pkg::ERR_RANGE;
            end
            aswdm_pkg::OP_CHKPT: begin
               priority if (!init_ff) err_in = aswdm_pkg::ERR_NOT_INIT;
               else if (!in_range)    err_in = aswdm_pkg::ERR_RANGE;
               else                   acc_in = 1'b1;
            end
            aswdm_pkg::OP_TICK: begin
               if (init_ff) begin
                  state_in = FSM_WALK;
                  rsp_load = 1'b0;
               end else begin
                  err_in = aswdm_pkg::ERR_NOT_INIT;
               end
            end
            aswdm_pkg::OP_QUERY: begin
               priority if (!init_ff) err_in = aswdm_pkg::ERR_NOT_INIT;
               else if (!in_range)    err_in = aswdm_pkg::ERR_RANGE;
               else begin
                  acc_in   = 1'b1;
                  lstat_in = query_status;
               end
            end
            default: begin
               acc_in = 1'b0;
            end
         endcase
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         init_ff      <= 1'b0;
         ovf_ff       <= 1'b1;
         count_ff     <= aswdm_pkg::DEF_ENTITY_COUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) count_ff <= csr_wr_data;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         acc_ff   <= acc_in;
         err_ff   <= err_in;
         lstat_ff <= lstat_in;
         gstat_ff <= gstat_in;
         feed_ff  <= feed_in;
         exp_ff   <= exp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_error_code    = err_ff;
   assign rsp_local_status  = lstat_ff;
   assign rsp_global_status = gstat_ff;
   assign rsp_feed_toggle   = feed_ff;
   assign rsp_newly_expired = exp_ff;

endmodule

// File: hdl/aswdm_cell.sv
// One supervision cell: alive counter, status, failure count and limits
// of a single entity, plus one stage of the main-tick walk.
// Depends on aswdm_pkg.
module aswdm_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  aswdm_pkg::cmd_type                cmd,
   input  logic                              sel,
   input  logic                              active,
   input  aswdm_pkg::token_type              tok_in,
   output aswdm_pkg::token_type              tok_out,
   output logic [aswdm_pkg::STAT_W-1:0]      rd_status
);

   logic [aswdm_pkg::ALIVE_W-1:0] count_ff, count_in;
   logic [aswdm_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [aswdm_pkg::TOL_W-1:0]   fc_ff, fc_in;
   logic [aswdm_pkg::ALIVE_W-1:0] min_ff, min_in;
   logic [aswdm_pkg::ALIVE_W-1:0] max_ff, max_in;
   logic [aswdm_pkg::TOL_W-1:0]   tol_ff, tol_in;
   aswdm_pkg::token_type          tok_ff, tok_in_nxt;

   logic [aswdm_pkg::TOL_W-1:0]   fc_inc;
   logic                          out_of_range;

   assign fc_inc = (fc_ff == aswdm_pkg::FC_MAX) ? fc_ff : fc_ff + 1'b1;
   assign out_of_range = (count_ff < min_ff) || (count_ff > max_ff);

   // state update: commands, then this cell's walk step
   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      fc_in      = fc_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      tol_in     = tol_ff;
      tok_in_nxt = tok_in;
      if (cmd.init) begin
         count_in  = '0;
         status_in = aswdm_pkg::STAT_OK;
         fc_in     = '0;
      end
      if (sel && cmd.load) begin
         min_in = cmd.alive_min;
         max_in = cmd.alive_max;
         tol_in = cmd.tol;
      end
      if (sel && cmd.chkpt) begin
         count_in = count_ff + 1'b1;
      end
      if (tok_in.valid && active) begin
         if (status_ff == aswdm_pkg::STAT_EXPIRED) begin
            tok_in_nxt.all_ok = 1'b0;
         end else if (out_of_range) begin
            fc_in             = fc_inc;
            tok_in_nxt.all_ok = 1'b0;
            count_in          = '0;
            if (fc_inc > tol_ff) begin
               status_in          = aswdm_pkg::STAT_EXPIRED;
               tok_in_nxt.expired = tok_in.expired + 1'b1;
            end else begin
               status_in = aswdm_pkg::STAT_FAILED;
            end
         end else begin
            status_in = aswdm_pkg::STAT_OK;
            fc_in     = '0;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= aswdm_pkg::STAT_OK;
         fc_ff     <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         tol_ff    <= '0;
         tok_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         status_ff <= status_in;
         fc_ff     <= fc_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         tol_ff    <= tol_in;
         tok_ff    <= tok_in_nxt;
      end
   end

   assign tok_out   = tok_ff;
   assign rd_status = sel ? status_ff : aswdm_pkg::STAT_OK;

endmodule
